// File: rtl/core/tqld_pkg.sv
package tqld_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int RUNTIME_W       = 16;
  localparam int ID_W            = 8;
  localparam int LOAD_W          = 21;
  localparam int ENTRY_W         = ID_W + RUNTIME_W;

  localparam logic [ID_W-1:0]   FIRST_ID = ID_W'(1);
  localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_DRAIN = 1'b1
  } opcode_t;

  typedef enum logic {
    ST_EMITTED = 1'b0,
    ST_REFUSED = 1'b1
  } status_t;

endpackage

// File: rtl/core/two_queue_least_load_dispatch_top.sv
// Two-queue least-load job dispatcher. A push beat is taken and busy stays low,
// so pushes may follow each other in every cycle; a push that finds its chosen
// queue full answers in the next cycle with a single refusal result (status 1,
// last 1, job_id 0). A drain beat raises busy, which stays high while the drain
// emits one job id per cycle for the queued jobs; the strobe of each result is
// registered behind the emit state, so the last result appears in the cycle in
// which busy is first low. The emission rate is set by the single read port of
// each queue memory, which returns one head entry per cycle. A drain of two
// empty queues gives no result and leaves busy low.
// Results are shown for one cycle under strobe and the receiver cannot hold
// them off; it must take every result as it comes.
module two_queue_least_load_dispatch_top #(
  parameter int QUEUE_DEPTH = tqld_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           opcode,
  input  logic [tqld_pkg::RUNTIME_W-1:0] job_runtime,
  output logic                           strobe,
  output logic [tqld_pkg::ID_W-1:0]      job_id,
  output logic                           status,
  output logic                           last
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam int RT_W  = tqld_pkg::RUNTIME_W;
  localparam int ID_W  = tqld_pkg::ID_W;
  localparam int LD_W  = tqld_pkg::LOAD_W;
  localparam int ENT_W = tqld_pkg::ENTRY_W;

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_t;

  state_t state;

  logic [PTR_W-1:0] head_a, tail_a, head_b, tail_b;
  logic [PTR_W-1:0] head_a_next, head_b_next;
  logic [LD_W-1:0]  load_a, load_b;
  logic [ID_W-1:0]  next_id;

  logic [ENT_W-1:0] mem_a [QUEUE_DEPTH];
  logic [ENT_W-1:0] mem_b [QUEUE_DEPTH];
  logic [ENT_W-1:0] rdata_a, rdata_b;

  logic             accept, to_a, push_full, push_ok, we_a, we_b;
  logic             empty_a, empty_b, take_a, drain_end;
  logic [PTR_W-1:0] tail_sel, head_sel;
  logic [LD_W-1:0]  load_sel_next;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [LD_W-1:0] load_add(input logic [LD_W-1:0] ld,
                                               input logic [RT_W-1:0] rt);
    logic [LD_W:0] sum;
    sum = {1'b0, ld} + (LD_W + 1)'(rt);
    load_add = sum[LD_W] ? tqld_pkg::LOAD_MAX : sum[LD_W-1:0];
  endfunction

  assign accept    = start && !busy;
  assign to_a      = (load_a <= load_b);
  assign tail_sel  = to_a ? tail_a : tail_b;
  assign head_sel  = to_a ? head_a : head_b;
  assign push_full = (ptr_next(tail_sel) == head_sel);
  assign push_ok   = accept && (opcode == tqld_pkg::OP_PUSH) && !push_full;
  assign we_a      = push_ok && to_a;
  assign we_b      = push_ok && !to_a;
  assign load_sel_next = load_add(to_a ? load_a : load_b, job_runtime);

  assign empty_a = (head_a == tail_a);
  assign empty_b = (head_b == tail_b);
  // A wins ties; once one queue runs dry the other simply empties in order.
  assign take_a  = !empty_a && (empty_b || (rdata_a[RT_W-1:0] <= rdata_b[RT_W-1:0]));

  always_comb begin
    head_a_next = head_a;
    head_b_next = head_b;
    if (state == S_EMIT) begin
      if (take_a) begin
        head_a_next = ptr_next(head_a);
      end else begin
        head_b_next = ptr_next(head_b);
      end
    end
  end

  assign drain_end = (head_a_next == tail_a) && (head_b_next == tail_b);

  // No push is taken during a drain, so the heads read here never race a write.
  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[tail_a] <= {next_id, job_runtime};
    end
    if (we_b) begin
      mem_b[tail_b] <= {next_id, job_runtime};
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem_a[head_a_next];
    rdata_b <= mem_b[head_b_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      busy    <= 1'b0;
      strobe  <= 1'b0;
      head_a  <= '0;
      tail_a  <= '0;
      head_b  <= '0;
      tail_b  <= '0;
      load_a  <= '0;
      load_b  <= '0;
      next_id <= tqld_pkg::FIRST_ID;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (opcode == tqld_pkg::OP_PUSH) begin
              if (push_full) begin
                strobe <= 1'b1;
                status <= tqld_pkg::ST_REFUSED;
                last   <= 1'b1;
                job_id <= '0;
              end else begin
                if (to_a) begin
                  tail_a <= ptr_next(tail_a);
                  load_a <= load_sel_next;
                end else begin
                  tail_b <= ptr_next(tail_b);
                  load_b <= load_sel_next;
                end
                next_id <= next_id + ID_W'(1);
              end
            end else begin
              load_a  <= '0;
              load_b  <= '0;
              next_id <= tqld_pkg::FIRST_ID;
              if (!(empty_a && empty_b)) begin
                state <= S_EMIT;
                busy  <= 1'b1;
              end
            end
          end
        end
        S_EMIT: begin
          strobe <= 1'b1;
          status <= tqld_pkg::ST_EMITTED;
          last   <= drain_end;
          job_id <= take_a ? rdata_a[ENT_W-1:RT_W] : rdata_b[ENT_W-1:RT_W];
          head_a <= head_a_next;
          head_b <= head_b_next;
          if (drain_end) begin
            state <= S_IDLE;
            busy  <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  a_refusal_shape: assert property (@(posedge clk) disable iff (rst)
    strobe && (status == tqld_pkg::ST_REFUSED) |-> last && (job_id == '0))
    else $error("refusal result with wrong id or last flag");

  a_no_write_in_drain: assert property (@(posedge clk) disable iff (rst)
    (we_a || we_b) |-> !busy)
    else $error("queue write during drain");

  a_drain_has_work: assert property (@(posedge clk) disable iff (rst)
    busy |-> !(empty_a && empty_b))
    else $error("drain running with both queues empty");

  a_emit_follows_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && (status == tqld_pkg::ST_EMITTED) |-> $past(busy))
    else $error("job id emitted outside a drain");

  a_last_ends_drain: assert property (@(posedge clk) disable iff (rst)
    strobe && (status == tqld_pkg::ST_EMITTED) && last |-> !busy && empty_a && empty_b)
    else $error("last result while jobs remain queued");

endmodule
